// ----- sv/iabw_pkg.sv -----
// Shared types and constants for the inverse affine bilinear warp.
package iabw_pkg;

    // Largest frame the image store holds
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAME_MIN  = 2;

    // Image store split into four banks by column and row parity
    localparam int BANK_AW    = 14;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_A00      = 3'd0,
        REG_A01      = 3'd1,
        REG_A10      = 3'd2,
        REG_A11      = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } t_reg_idx;

    // Input item modes
    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_SAMPLE = 1'b1
    } t_mode;

    typedef logic signed [31:0] t_q32;

    // Matrix and bias as held in the configuration registers
    typedef struct packed {
        logic signed [15:0] a00;
        logic signed [15:0] a01;
        logic signed [15:0] a10;
        logic signed [15:0] a11;
        logic signed [19:0] bx;
        logic signed [19:0] by;
    } t_mat;

    // Inverse matrix (Q16.16), inverse offsets (Q24.8) and status
    typedef struct packed {
        t_q32 c0;
        t_q32 c1;
        t_q32 c2;
        t_q32 c3;
        t_q32 o0;
        t_q32 o1;
        logic singular;
        logic busy;
    } t_inv;

    // Store access request after coordinate mapping and clipping
    typedef struct packed {
        logic       valid;
        logic       load;
        logic [7:0] pixel;
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] ix;
        logic [7:0] iy;
        logic [7:0] fx;
        logic [7:0] fy;
    } t_req;

endpackage

// ----- sv/iabw_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module iabw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/iabw_inv.sv -----
// Matrix inversion sequencer: determinant, serial divider, offset products.
module iabw_inv import iabw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_restart,
    input  t_mat i_mat,
    output t_inv o_inv
);

    typedef enum logic [7:0] {
        S_DET0 = 8'b0000_0001,
        S_DET1 = 8'b0000_0010,
        S_PREP = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_QSAT = 8'b0001_0000,
        S_OFF0 = 8'b0010_0000,
        S_OFF1 = 8'b0100_0000,
        S_IDLE = 8'b1000_0000
    } t_inv_state;

    // In OFF1, r_fin tells the accumulate cycle from the store cycle
    t_inv_state r_state, n_state;
    logic signed [32:0] r_det;
    logic [31:0]        r_dmag;
    logic [1:0]         r_k;
    logic [5:0]         r_cnt;
    logic [31:0]        r_rem;
    logic [43:0]        r_quo;
    logic               r_neg;
    logic               r_j;
    logic               r_fin;
    logic signed [52:0] r_acc;
    t_q32               r_c0, r_c1, r_c2, r_c3, r_o0, r_o1;
    logic               r_singular;

    logic signed [15:0] w_da, w_db;
    logic signed [31:0] w_dprod;
    logic [1:0]         w_kload;
    logic signed [15:0] w_num;
    logic               w_nsign;
    logic [15:0]        w_nmag;
    logic [32:0]        w_trial;
    logic [32:0]        w_diff;
    logic               w_ge;
    t_q32               w_coef;
    t_q32               w_cj, w_cj2;
    logic signed [19:0] w_mb;
    t_q32               w_mc;
    logic signed [51:0] w_prod;
    logic signed [53:0] w_nacc;
    logic signed [37:0] w_sh;
    t_q32               w_off;

    // Determinant partial products, one multiply per cycle
    assign w_da    = (r_state == S_DET1) ? i_mat.a01 : i_mat.a00;
    assign w_db    = (r_state == S_DET1) ? i_mat.a10 : i_mat.a11;
    assign w_dprod = w_da * w_db;

    // Numerator for the entry about to be divided: a11, -a01, -a10, a00
    assign w_kload = (r_state == S_PREP) ? 2'd0 : r_k + 2'd1;
    always_comb begin
        unique case (w_kload)
            2'd0: begin w_num = i_mat.a11; w_nsign = i_mat.a11[15];  end
            2'd1: begin w_num = i_mat.a01; w_nsign = ~i_mat.a01[15]; end
            2'd2: begin w_num = i_mat.a10; w_nsign = ~i_mat.a10[15]; end
            default: begin w_num = i_mat.a00; w_nsign = i_mat.a00[15]; end
        endcase
    end
    assign w_nmag = w_num[15] ? 16'(-w_num) : w_num;

    // Restoring division, one quotient bit a cycle
    assign w_trial = {r_rem, r_quo[43]};
    assign w_ge    = (w_trial >= {1'b0, r_dmag});
    assign w_diff  = w_trial - {1'b0, r_dmag};

    // Signed, saturated quotient
    always_comb begin
        if (!r_neg) begin
            w_coef = (r_quo > 44'h0007FFFFFFF) ? 32'sh7FFFFFFF : r_quo[31:0];
        end else begin
            w_coef = (r_quo > 44'h00080000000) ? 32'sh80000000 : (~r_quo[31:0]) + 32'd1;
        end
    end

    // Offset products: b0*inv[j], then b1*inv[2+j]
    assign w_cj   = r_j ? r_c1 : r_c0;
    assign w_cj2  = r_j ? r_c3 : r_c2;
    assign w_mb   = (r_state == S_OFF1) ? i_mat.by : i_mat.bx;
    assign w_mc   = (r_state == S_OFF1) ? w_cj2 : w_cj;
    assign w_prod = w_mb * w_mc;

    // floor(-s / 2^16), saturated to 32 bits
    assign w_nacc = -{r_acc[52], r_acc};
    assign w_sh   = w_nacc[53:16];
    always_comb begin
        if (w_sh[37:31] == {7{w_sh[31]}}) begin
            w_off = w_sh[31:0];
        end else if (w_sh[37]) begin
            w_off = 32'sh80000000;
        end else begin
            w_off = 32'sh7FFFFFFF;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (i_restart) begin
            n_state = S_DET0;
        end else begin
            unique case (r_state)
                S_DET0: n_state = S_DET1;
                S_DET1: n_state = S_PREP;
                S_PREP: n_state = (r_det == '0) ? S_IDLE : S_DIV;
                S_DIV:  n_state = (r_cnt == 6'd43) ? S_QSAT : S_DIV;
                S_QSAT: n_state = (r_k == 2'd3) ? S_OFF0 : S_DIV;
                S_OFF0: n_state = S_OFF1;
                S_OFF1: begin
                    if (!r_fin) begin
                        n_state = S_OFF1;
                    end else begin
                        n_state = r_j ? S_IDLE : S_OFF0;
                    end
                end
                S_IDLE: n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DET0;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers; OFF1 runs twice: accumulate, then store the offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0;
            r_o0 <= '0; r_o1 <= '0;
            r_singular <= 1'b0;
            r_fin <= 1'b0;
            r_j <= 1'b0;
            r_k <= 2'd0;
            r_cnt <= 6'd0;
        end else if (!i_restart) begin
            unique case (r_state)
                S_DET0: r_det <= {w_dprod[31], w_dprod};
                S_DET1: r_det <= r_det - {w_dprod[31], w_dprod};
                S_PREP: begin
                    r_singular <= (r_det == '0);
                    r_dmag     <= r_det[32] ? 32'(-r_det) : r_det[31:0];
                    r_k        <= 2'd0;
                    r_cnt      <= 6'd0;
                    r_rem      <= '0;
                    r_quo      <= {w_nmag, 28'd0};
                    r_neg      <= w_nsign ^ r_det[32];
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
                    r_quo <= {r_quo[42:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                end
                S_QSAT: begin
                    unique case (r_k)
                        2'd0: r_c0 <= w_coef;
                        2'd1: r_c1 <= w_coef;
                        2'd2: r_c2 <= w_coef;
                        default: r_c3 <= w_coef;
                    endcase
                    r_k   <= w_kload;
                    r_cnt <= 6'd0;
                    r_rem <= '0;
                    r_quo <= {w_nmag, 28'd0};
                    r_neg <= w_nsign ^ r_det[32];
                    r_j   <= 1'b0;
                    r_fin <= 1'b0;
                end
                S_OFF0: begin
                    r_acc <= {w_prod[51], w_prod};
                    r_fin <= 1'b0;
                end
                S_OFF1: begin
                    if (!r_fin) begin
                        r_acc <= r_acc + {w_prod[51], w_prod};
                        r_fin <= 1'b1;
                    end else begin
                        if (r_j) begin
                            r_o1 <= w_off;
                        end else begin
                            r_o0 <= w_off;
                        end
                        r_j <= 1'b1;
                    end
                end
                S_IDLE: r_fin <= 1'b0;
                default: r_fin <= 1'b0;
            endcase
        end
    end

    assign o_inv.c0       = r_c0;
    assign o_inv.c1       = r_c1;
    assign o_inv.c2       = r_c2;
    assign o_inv.c3       = r_c3;
    assign o_inv.o0       = r_o0;
    assign o_inv.o1       = r_o1;
    assign o_inv.singular = r_singular;
    assign o_inv.busy     = (r_state != S_IDLE);

endmodule

// ----- sv/iabw_map.sv -----
// Coordinate pipeline: capture, inverse products, source coordinate, clipping.
module iabw_map import iabw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_mode,
    input  logic [7:0] i_pixel,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  t_inv       i_inv,
    input  logic [7:0] i_wm2,
    input  logic [7:0] i_hm2,
    output t_req       o_req
);

    // Stage 1: item capture
    logic       r1_valid, r1_load;
    logic [7:0] r1_pix, r1_x, r1_y;
    // Stage 2: coordinate times inverse entries
    logic       r2_valid, r2_load;
    logic [7:0] r2_pix, r2_x, r2_y;
    logic signed [40:0] r2_xa, r2_ya, r2_xb, r2_yb;
    // Stage 3: source coordinate in Q.8
    logic       r3_valid, r3_load;
    logic [7:0] r3_pix, r3_x, r3_y;
    logic signed [34:0] r3_sx, r3_sy;

    logic signed [41:0] w_sumx, w_sumy;
    logic [15:0]        w_cx, w_cy;

    function automatic logic [15:0] clip_q8(input logic signed [34:0] v,
                                            input logic [7:0] m2);
        logic [15:0] hi;
        hi = {m2, 8'h00};
        if (v[34]) begin
            return 16'd0;
        end else if (v > $signed({19'd0, hi})) begin
            return hi;
        end else begin
            return v[15:0];
        end
    endfunction

    assign w_sumx = {r2_xa[40], r2_xa} + {r2_ya[40], r2_ya};
    assign w_sumy = {r2_xb[40], r2_xb} + {r2_yb[40], r2_yb};

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r1_load <= (i_mode == MODE_LOAD);
        r1_pix  <= i_pixel;
        r1_x    <= i_x;
        r1_y    <= i_y;

        r2_load <= r1_load;
        r2_pix  <= r1_pix;
        r2_x    <= r1_x;
        r2_y    <= r1_y;
        r2_xa   <= $signed({1'b0, r1_x}) * i_inv.c0;
        r2_ya   <= $signed({1'b0, r1_y}) * i_inv.c2;
        r2_xb   <= $signed({1'b0, r1_x}) * i_inv.c1;
        r2_yb   <= $signed({1'b0, r1_y}) * i_inv.c3;

        r3_load <= r2_load;
        r3_pix  <= r2_pix;
        r3_x    <= r2_x;
        r3_y    <= r2_y;
        r3_sx   <= {w_sumx[41], w_sumx[41:8]} + {{3{i_inv.o0[31]}}, i_inv.o0};
        r3_sy   <= {w_sumy[41], w_sumy[41:8]} + {{3{i_inv.o1[31]}}, i_inv.o1};
    end

    // Clip to the frame, split into integer and fraction
    assign w_cx = clip_q8(r3_sx, i_wm2);
    assign w_cy = clip_q8(r3_sy, i_hm2);

    assign o_req.valid = r3_valid;
    assign o_req.load  = r3_load;
    assign o_req.pixel = r3_pix;
    assign o_req.px    = r3_x;
    assign o_req.py    = r3_y;
    assign o_req.ix    = w_cx[15:8];
    assign o_req.iy    = w_cy[15:8];
    assign o_req.fx    = w_cx[7:0];
    assign o_req.fy    = w_cy[7:0];

endmodule

// ----- sv/iabw_interp.sv -----
// Banked image store, neighbour fetch and bilinear blend.
module iabw_interp import iabw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  logic        i_singular,
    output logic        o_strobe,
    output logic [15:0] o_sample_value,
    output logic        o_singular
);

    logic [7:0]  w_rd [4];
    logic [8:0]  w_wx0, w_wy0;

    // Stage 4: store read, weights
    logic        r4_valid, r4_ix0, r4_iy0;
    logic [16:0] r4_w00, r4_w10, r4_w01, r4_w11;
    // Stage 5: weighted neighbours
    logic        r5_valid;
    logic [23:0] r5_m00, r5_m10, r5_m01, r5_m11;
    // Stage 6: result
    logic        r6_valid, r6_sing;
    logic [15:0] r6_value;

    logic [7:0]  w_p00, w_p10, w_p01, w_p11;
    logic [23:0] w_sum;

    // One bank per column/row parity: the four neighbours never share a bank
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BID = 2'(b);
        logic [7:0]         w_xb, w_yb;
        logic               w_we;
        logic [BANK_AW-1:0] w_waddr, w_raddr;

        assign w_xb    = (i_req.ix[0] == BID[0]) ? i_req.ix : i_req.ix + 8'd1;
        assign w_yb    = (i_req.iy[0] == BID[1]) ? i_req.iy : i_req.iy + 8'd1;
        assign w_raddr = {w_yb[7:1], w_xb[7:1]};
        assign w_waddr = {i_req.py[7:1], i_req.px[7:1]};
        assign w_we    = i_req.valid && i_req.load &&
                         ({i_req.py[0], i_req.px[0]} == BID);

        iabw_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (i_req.pixel),
            .i_raddr (w_raddr),
            .o_rdata (w_rd[b])
        );
    end

    assign w_wx0 = 9'd256 - {1'b0, i_req.fx};
    assign w_wy0 = 9'd256 - {1'b0, i_req.fy};

    // Undo the bank scramble
    assign w_p00 = w_rd[{r4_iy0, r4_ix0}];
    assign w_p10 = w_rd[{r4_iy0, ~r4_ix0}];
    assign w_p01 = w_rd[{~r4_iy0, r4_ix0}];
    assign w_p11 = w_rd[{~r4_iy0, ~r4_ix0}];

    assign w_sum = r5_m00 + r5_m10 + r5_m01 + r5_m11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r4_valid <= i_req.valid && !i_req.load;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    // Operands widened to the product width so nothing wraps
    always_ff @(posedge i_clk) begin
        r4_ix0 <= i_req.ix[0];
        r4_iy0 <= i_req.iy[0];
        r4_w00 <= {8'd0, w_wx0} * {8'd0, w_wy0};
        r4_w10 <= {9'd0, i_req.fx} * {8'd0, w_wy0};
        r4_w01 <= {8'd0, w_wx0} * {9'd0, i_req.fy};
        r4_w11 <= {9'd0, i_req.fx} * {9'd0, i_req.fy};

        r5_m00 <= {7'd0, r4_w00} * {16'd0, w_p00};
        r5_m10 <= {7'd0, r4_w10} * {16'd0, w_p10};
        r5_m01 <= {7'd0, r4_w01} * {16'd0, w_p01};
        r5_m11 <= {7'd0, r4_w11} * {16'd0, w_p11};

        r6_sing  <= i_singular;
        r6_value <= i_singular ? 16'd0 : w_sum[23:8];
    end

    assign o_strobe       = r6_valid;
    assign o_sample_value = r6_value;
    assign o_singular     = r6_sing;

endmodule

// ----- sv/inverse_affine_bilinear_warp.sv -----
// Top level: configuration registers, inversion sequencer, sample pipeline.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------
//  item in   | start, busy               | i_mode, i_pixel_in, i_pos_x, i_pos_y
//  result    | o_strobe                  | o_sample_value, o_singular
//  config    | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item a cycle while busy is low; a sample passes the capture, inverse product,
// source coordinate, store read, weighted neighbour and result registers in turn.
// After reset, and after each write to a matrix or bias register, busy stays high
// for the inversion: determinant, serial division of the four inverse entries
// and the two offset products; a singular matrix skips division and offsets.
// Reset is synchronous; the result side has no back-pressure.
module inverse_affine_bilinear_warp import iabw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [7:0]  i_pixel_in,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    output logic        o_strobe,
    output logic [15:0] o_sample_value,
    output logic        o_singular,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    t_mat       r_mat;
    logic [8:0] r_fw, r_fh;
    logic       w_cfg_wr, w_restart, w_accept;
    t_inv       w_inv;
    t_req       w_req;
    logic [8:0] w_wc, w_hc;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_restart   = w_cfg_wr && (t_reg_idx'(i_cfg_index) <= REG_OFFSET_Y);
    assign w_accept    = start && !busy;
    assign busy        = w_inv.busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat.a00 <= 16'sd4096;
            r_mat.a01 <= '0;
            r_mat.a10 <= '0;
            r_mat.a11 <= 16'sd4096;
            r_mat.bx  <= '0;
            r_mat.by  <= '0;
            r_fw      <= 9'(MAX_WIDTH);
            r_fh      <= 9'(MAX_HEIGHT);
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_A00:      r_mat.a00 <= i_cfg_data[15:0];
                REG_A01:      r_mat.a01 <= i_cfg_data[15:0];
                REG_A10:      r_mat.a10 <= i_cfg_data[15:0];
                REG_A11:      r_mat.a11 <= i_cfg_data[15:0];
                REG_OFFSET_X: r_mat.bx  <= i_cfg_data;
                REG_OFFSET_Y: r_mat.by  <= i_cfg_data;
                REG_WIDTH:    r_fw      <= i_cfg_data[8:0];
                REG_HEIGHT:   r_fh      <= i_cfg_data[8:0];
                default:      r_fw      <= r_fw;
            endcase
        end
    end

    // Frame size clamped to the store
    assign w_wc = (r_fw < 9'(FRAME_MIN)) ? 9'(FRAME_MIN) :
                  (r_fw > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : r_fw;
    assign w_hc = (r_fh < 9'(FRAME_MIN)) ? 9'(FRAME_MIN) :
                  (r_fh > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : r_fh;

    iabw_inv u_inv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_mat     (r_mat),
        .o_inv     (w_inv)
    );

    iabw_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_mode   (i_mode),
        .i_pixel  (i_pixel_in),
        .i_x      (i_pos_x),
        .i_y      (i_pos_y),
        .i_inv    (w_inv),
        .i_wm2    (8'(w_wc - 9'(FRAME_MIN))),
        .i_hm2    (8'(w_hc - 9'(FRAME_MIN))),
        .o_req    (w_req)
    );

    iabw_interp u_interp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .i_singular     (w_inv.singular),
        .o_strobe       (o_strobe),
        .o_sample_value (o_sample_value),
        .o_singular     (o_singular)
    );

endmodule

// ----- sv/iabw_chk.sv -----
// Port-level checker for the warp block, bound to the top level.
module iabw_chk import iabw_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_mode,
    input logic        o_strobe,
    input logic [15:0] o_sample_value,
    input logic        o_singular,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index
);

    // A sample item gives a result strobe
    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_SAMPLE) |-> ##6 o_strobe)
        else $error("sample item lost");

    // A load gives no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_LOAD) |-> ##6 !o_strobe)
        else $error("result without a sample item");

    // Singular matrix forces a zero value
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_singular) |-> (o_sample_value == 16'd0))
        else $error("non-zero value with singular matrix");

    // A matrix or bias write starts a new inversion
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && t_reg_idx'(i_cfg_index) <= REG_OFFSET_Y) |=> busy)
        else $error("no inversion after matrix write");

endmodule

bind inverse_affine_bilinear_warp iabw_chk u_iabw_chk (.*);

// ----- test/inverse_affine_bilinear_warp_tb.sv -----
// Self-checking testbench for the inverse affine bilinear warp block.
`timescale 1ns / 1ps

module inverse_affine_bilinear_warp_tb;
    import iabw_pkg::*;

    // One expected sample result
    typedef struct {
        logic [15:0] value;
        logic        singular;
    } t_sample_exp;

    // Scoreboard: mirrors registers, image and inverse, holds expected samples
    class warp_scoreboard;
        logic [19:0]  cfg_regs [8];
        logic [7:0]   image [MAX_WIDTH*MAX_HEIGHT];
        longint       inv_coef [4];
        longint       inv_off [2];
        bit           inv_valid;
        t_sample_exp  pending_samples [$];
        int           errors;

        function new();
            cfg_regs[REG_A00] = 20'd4096;
            cfg_regs[REG_A01] = 20'd0;
            cfg_regs[REG_A10] = 20'd0;
            cfg_regs[REG_A11] = 20'd4096;
            cfg_regs[REG_OFFSET_X] = 20'd0;
            cfg_regs[REG_OFFSET_Y] = 20'd0;
            cfg_regs[REG_WIDTH] = 20'd256;
            cfg_regs[REG_HEIGHT] = 20'd256;
            inv_valid = 0;
            errors = 0;
        endfunction

        function longint coef(t_reg_idx r);
            return longint'($signed(cfg_regs[r][15:0]));
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint clip(longint v, longint hi);
            return v < 0 ? 0 : (v > hi ? hi : v);
        endfunction

        function int frame_w();
            return int'(clip(longint'(cfg_regs[REG_WIDTH][8:0]) - 2, MAX_WIDTH - 2)) + 2;
        endfunction

        function int frame_h();
            return int'(clip(longint'(cfg_regs[REG_HEIGHT][8:0]) - 2, MAX_HEIGHT - 2)) + 2;
        endfunction

        function void set_reg(t_reg_idx r, logic [19:0] d);
            if (r == REG_WIDTH || r == REG_HEIGHT)
                cfg_regs[r] = {11'd0, d[8:0]};
            else if (r == REG_OFFSET_X || r == REG_OFFSET_Y)
                cfg_regs[r] = d;
            else
                cfg_regs[r] = {4'd0, d[15:0]};
            if (r != REG_WIDTH && r != REG_HEIGHT)
                inv_valid = 0;
        endfunction

        function longint det();
            return coef(REG_A00) * coef(REG_A11) - coef(REG_A01) * coef(REG_A10);
        endfunction

        // Inverse in Q16.16 and negated mapped bias in Q24.8
        function void invert(longint d);
            longint num [4];
            longint bx, by, s;
            num[0] = coef(REG_A11);
            num[1] = -coef(REG_A01);
            num[2] = -coef(REG_A10);
            num[3] = coef(REG_A00);
            bx = longint'($signed(cfg_regs[REG_OFFSET_X]));
            by = longint'($signed(cfg_regs[REG_OFFSET_Y]));
            for (int j = 0; j < 4; j++)
                inv_coef[j] = sat32((num[j] * 64'sd268435456) / d);
            for (int j = 0; j < 2; j++) begin
                s = bx * inv_coef[j] + by * inv_coef[2+j];
                inv_off[j] = sat32((-s) >>> 16);
            end
            inv_valid = 1;
        endfunction

        // Note an accepted item and work out its result, if any
        function void note(t_mode m, logic [7:0] pix, logic [7:0] x, logic [7:0] y);
            t_sample_exp e;
            longint d, sx, sy, fx, fy, acc;
            int base;
            if (m == MODE_LOAD) begin
                image[int'(y) * MAX_WIDTH + int'(x)] = pix;
                return;
            end
            d = det();
            if (d == 0) begin
                e.value = 16'd0;
                e.singular = 1'b1;
                pending_samples.push_back(e);
                return;
            end
            if (!inv_valid)
                invert(d);
            sx = ((longint'(x) * inv_coef[0] + longint'(y) * inv_coef[2]) >>> 8) + inv_off[0];
            sy = ((longint'(x) * inv_coef[1] + longint'(y) * inv_coef[3]) >>> 8) + inv_off[1];
            sx = clip(sx, longint'(frame_w() - 2) * 256);
            sy = clip(sy, longint'(frame_h() - 2) * 256);
            fx = sx & 255;
            fy = sy & 255;
            base = int'(sy >>> 8) * MAX_WIDTH + int'(sx >>> 8);
            acc = (256 - fx) * (256 - fy) * longint'(image[base])
                + fx * (256 - fy) * longint'(image[base+1])
                + (256 - fx) * fy * longint'(image[base+MAX_WIDTH])
                + fx * fy * longint'(image[base+MAX_WIDTH+1]);
            e.value = 16'((acc >>> 8) & 16'hFFFF);
            e.singular = 1'b0;
            pending_samples.push_back(e);
        endfunction

        function void check(logic [15:0] value, logic sing);
            t_sample_exp e;
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected result value=%h singular=%b", $time, value, sing);
                errors++;
                return;
            end
            e = pending_samples.pop_front();
            if (value !== e.value) begin
                $display("%0t: sample_value expected %h actual %h", $time, e.value, value);
                errors++;
            end
            if (sing !== e.singular) begin
                $display("%0t: singular expected %b actual %b", $time, e.singular, sing);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [7:0]  i_pixel_in;
    logic [7:0]  i_pos_x;
    logic [7:0]  i_pos_y;
    logic        o_strobe;
    logic [15:0] o_sample_value;
    logic        o_singular;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    warp_scoreboard sb;
    bit             pixel_written [MAX_WIDTH*MAX_HEIGHT];
    int             burst_left;

    inverse_affine_bilinear_warp i_dut (.*);

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check(o_sample_value, o_singular);
    end

    // Send one item, holding start until it is taken
    task automatic send_item(t_mode m, logic [7:0] pix, logic [7:0] x, logic [7:0] y);
        @(negedge i_clk);
        start = 1'b1;
        i_mode = m;
        i_pixel_in = pix;
        i_pos_x = x;
        i_pos_y = y;
        do @(posedge i_clk); while (busy);
        sb.note(m, pix, x, y);
        if (m == MODE_LOAD)
            pixel_written[int'(y) * MAX_WIDTH + int'(x)] = 1;
    endtask

    // Bursty sender: random gaps between random-length bursts
    task automatic paced_item(t_mode m, logic [7:0] pix, logic [7:0] x, logic [7:0] y);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_item(m, pix, x, y);
    endtask

    // Wait until every result has arrived and the pipeline has emptied
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_samples.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx r, logic [19:0] d);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = r;
        i_cfg_data = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(r, d);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [15:0] a00, logic [15:0] a01, logic [15:0] a10,
                             logic [15:0] a11, logic [19:0] bx, logic [19:0] by,
                             logic [8:0] w, logic [8:0] h);
        drain();
        write_reg(REG_A00, {4'd0, a00});
        write_reg(REG_A01, {4'd0, a01});
        write_reg(REG_A10, {4'd0, a10});
        write_reg(REG_A11, {4'd0, a11});
        write_reg(REG_OFFSET_X, bx);
        write_reg(REG_OFFSET_Y, by);
        write_reg(REG_WIDTH, {11'd0, w});
        write_reg(REG_HEIGHT, {11'd0, h});
    endtask

    // Load every pixel of the frame not yet written, so samples read known data
    task automatic fill_frame();
        for (int y = 0; y < sb.frame_h(); y++)
            for (int x = 0; x < sb.frame_w(); x++)
                if (!pixel_written[y * MAX_WIDTH + x])
                    paced_item(MODE_LOAD, 8'($urandom), 8'(x), 8'(y));
    endtask

    // Random mix of loads and samples within the current setting
    task automatic random_items(int n);
        int w, h;
        logic [7:0] x, y;
        w = sb.frame_w();
        h = sb.frame_h();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 3) begin
                if ($urandom_range(0, 1) == 0) begin
                    x = 8'($urandom_range(0, w - 1));
                    y = 8'($urandom_range(0, h - 1));
                end else begin
                    x = 8'($urandom);
                    y = 8'($urandom);
                end
                paced_item(MODE_LOAD, 8'($urandom), x, y);
            end else begin
                if ($urandom_range(0, 2) != 0) begin
                    x = 8'($urandom_range(0, (w + 8 > 255) ? 255 : w + 8));
                    y = 8'($urandom_range(0, (h + 8 > 255) ? 255 : h + 8));
                end else begin
                    x = 8'($urandom);
                    y = 8'($urandom);
                end
                paced_item(MODE_SAMPLE, 8'($urandom), x, y);
            end
        end
    endtask

    // Limit on run time
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [15:0] a00, a01, a10, a11;
        logic [19:0] bx, by;
        logic [8:0]  w, h;
        sb = new();
        burst_left = 0;
        start = 1'b0;
        i_mode = MODE_LOAD;
        i_pixel_in = 8'd0;
        i_pos_x = 8'd0;
        i_pos_y = 8'd0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_A00;
        i_cfg_data = 20'd0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: 4x4 frame, half- and quarter-pixel shifts, extreme pixels and positions
        write_all(16'd4096, 16'd0, 16'd0, 16'd4096, 20'h00080, 20'hFFFC0, 9'd4, 9'd4);
        for (int k = 0; k < 16; k++)
            send_item(MODE_LOAD, (k % 3 == 0) ? 8'd255 : ((k % 3 == 1) ? 8'd0 : 8'(k * 17)),
                      8'(k % 4), 8'(k / 4));
        for (int y = 0; y < 4; y++) pixel_written[y * MAX_WIDTH + 0] = 1;
        send_item(MODE_SAMPLE, 8'd0, 8'd0, 8'd0);
        send_item(MODE_SAMPLE, 8'd255, 8'd1, 8'd2);
        send_item(MODE_SAMPLE, 8'd0, 8'd255, 8'd255);
        send_item(MODE_SAMPLE, 8'd0, 8'd3, 8'd0);

        // Directed: singular matrix at the positive extreme
        write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 20'd0, 20'd0, 9'd4, 9'd4);
        send_item(MODE_SAMPLE, 8'd0, 8'd2, 8'd1);
        send_item(MODE_SAMPLE, 8'd0, 8'd255, 8'd0);

        // Directed: negative and positive extremes, frame sizes below and above range
        write_all(16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 20'h7FFFF, 20'h80000, 9'd0, 9'd511);
        fill_frame();
        random_items(20);
        write_all(16'h7FFF, 16'h8000, 16'h0100, 16'h8000, 20'h80000, 20'h7FFFF, 9'd511, 9'd1);
        fill_frame();
        random_items(20);

        // Random settings: mostly small frames, near-identity or fully random maps
        for (int p = 0; p < 16; p++) begin
            if (p % 3 != 2) begin
                a00 = 16'(4096 + int'($urandom_range(0, 4096)) - 2048);
                a01 = 16'(int'($urandom_range(0, 3000)) - 1500);
                a10 = 16'(int'($urandom_range(0, 3000)) - 1500);
                a11 = 16'(4096 + int'($urandom_range(0, 4096)) - 2048);
                bx = 20'(int'($urandom_range(0, 4096)) - 2048);
                by = 20'(int'($urandom_range(0, 4096)) - 2048);
            end else begin
                a00 = 16'($urandom);
                a01 = 16'($urandom);
                a10 = 16'($urandom);
                a11 = 16'($urandom);
                bx = 20'($urandom);
                by = 20'($urandom);
            end
            if (p == 7) begin
                a01 = 16'd0;
                a11 = 16'd0;
            end
            w = (p == 5) ? 9'd256 : 9'($urandom_range(2, 14));
            h = (p == 11) ? 9'd256 : 9'($urandom_range(2, 14));
            if (p == 5) h = 9'd3;
            if (p == 11) w = 9'd2;
            write_all(a00, a01, a10, a11, bx, by, w, h);
            fill_frame();
            random_items(32);
        end

        drain();
        if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/iabw_pkg.sv
sv/iabw_ram.sv
sv/iabw_inv.sv
sv/iabw_map.sv
sv/iabw_interp.sv
sv/inverse_affine_bilinear_warp.sv
sv/iabw_chk.sv
test/inverse_affine_bilinear_warp_tb.sv
